FILE: src/lcdf_pkg.sv
// Shared types and constants of the sync/length/CRC-16 deframer.
package lcdf_pkg;

   localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [7:0]  SYNC_BYTE_RESET  = 8'h5A;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd1538;
   localparam logic [15:0] MIN_LENGTH_RESET = 16'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYNC_BYTE  = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MIN_LENGTH = 2'd2;

   // Frame status codes
   localparam logic [1:0] ST_GOOD  = 2'd0;
   localparam logic [1:0] ST_CRC   = 2'd1;
   localparam logic [1:0] ST_LONG  = 2'd2;
   localparam logic [1:0] ST_SHORT = 2'd3;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        frame_end;
      logic [1:0]  status;
      logic [15:0] payload_len;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

FILE: src/lcdf_front.sv
// Front end: frame parser with CSRs, running CRC and result classification.
module lcdf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                res_valid,
   output lcdf_pkg::result_type res
);
   import lcdf_pkg::*;

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC_LO  = 3'd5,
      PH_CRC_HI  = 3'd6
   } phase_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crclo_ff, crclo_in;
   logic [7:0]  sync_ff;
   logic [15:0] max_ff;
   logic [15:0] min_ff;

   logic [15:0] crc_next;
   logic [15:0] crc_seed;
   logic [15:0] len_new;
   logic [15:0] cnt_inc;

   assign crc_next = crc_byte(crc_ff, in_byte);
   assign crc_seed = crc_byte(CRC_INIT, in_byte);
   assign len_new  = {in_byte, len_ff[7:0]};
   assign cnt_inc  = cnt_ff + 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      len_in           = len_ff;
      cnt_in           = cnt_ff;
      crc_in           = crc_ff;
      crclo_in         = crclo_ff;
      res_valid        = 1'b0;
      res.payload_byte = 8'h00;
      res.frame_end    = 1'b0;
      res.status       = ST_GOOD;
      res.payload_len  = len_ff;
      if (in_valid) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (in_byte == sync_ff) begin
                  crc_in   = crc_next;
                  phase_in = PH_LEN_LO;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_LEN_LO: begin
               crc_in   = crc_next;
               len_in   = {8'h00, in_byte};
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               crc_in          = crc_next;
               len_in          = len_new;
               cnt_in          = 16'd0;
               res.payload_len = len_new;
               priority if (len_new > max_ff) begin
                  phase_in      = PH_SYNC1;
                  res_valid     = 1'b1;
                  res.frame_end = 1'b1;
                  res.status    = ST_LONG;
               end else if (len_new < min_ff) begin
                  phase_in      = PH_SYNC1;
                  res_valid     = 1'b1;
                  res.frame_end = 1'b1;
                  res.status    = ST_SHORT;
               end else begin
                  phase_in = (len_new == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in           = crc_next;
               cnt_in           = cnt_inc;
               if (cnt_inc >= len_ff) begin
                  phase_in = PH_CRC_LO;
               end
               res_valid        = 1'b1;
               res.payload_byte = in_byte;
            end
            PH_CRC_LO: begin
               crclo_in = in_byte;
               phase_in = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               phase_in      = PH_SYNC1;
               res_valid     = 1'b1;
               res.frame_end = 1'b1;
               res.status    = ({in_byte, crclo_ff} == crc_ff) ? ST_GOOD : ST_CRC;
            end
            default: begin
               phase_in = PH_SYNC1;
               if (in_byte == sync_ff) begin
                  crc_in   = crc_seed;
                  phase_in = PH_SYNC2;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         len_ff   <= 16'd0;
         cnt_ff   <= 16'd0;
         crc_ff   <= CRC_INIT;
         crclo_ff <= 8'h00;
         sync_ff  <= SYNC_BYTE_RESET;
         max_ff   <= MAX_LENGTH_RESET;
         min_ff   <= MIN_LENGTH_RESET;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         crclo_ff <= crclo_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SYNC_BYTE:  sync_ff <= csr_wdata[7:0];
               CSR_MAX_LENGTH: max_ff  <= csr_wdata;
               CSR_MIN_LENGTH: min_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: src/lcdf_fifo.sv
// Short result queue between the parser and the output stage.
module lcdf_fifo #(
   parameter int unsigned DEPTH = lcdf_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  lcdf_pkg::result_type   wr_data,
   input  logic                   rd_en,
   output lcdf_pkg::result_type   rd_data,
   output lcdf_pkg::fifo_stat_type stat
);
   import lcdf_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   result_type      mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr;
   logic            do_rd;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr      = wr_en && !stat.full;
   assign do_rd      = rd_en && !stat.empty;
   assign rd_data    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/lcdf_back.sv
// Back end: output register that drains the queue and serves the result port.
module lcdf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdf_pkg::fifo_stat_type q_stat,
   input  lcdf_pkg::result_type    q_data,
   output logic                    q_rd,
   input  logic                    out_pop,
   output logic                    out_valid,
   output lcdf_pkg::result_type    out_data
);
   import lcdf_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Refill from a non-empty queue whenever the register is free or being taken in this cycle
   assign q_rd      = !q_stat.empty && (!valid_ff || out_pop);
   assign valid_in  = q_rd || (valid_ff && !out_pop);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         data_ff <= q_data;
      end
   end

endmodule

FILE: src/sync_length_crc16_deframer_top.sv
// Top level of the sync/length/CRC-16 frame deframer.
//
// Usage:
//  - req_*: one received byte per transfer (push while full is low). The parser
//    hunts for two sync bytes, takes a little-endian 16-bit length, checks it
//    against min_length/max_length, then passes payload bytes and checks the
//    trailing little-endian CRC-16/MODBUS taken over sync, length and payload.
//  - rsp_*: queue-style result port. Payload bytes come out with frame_end low;
//    each frame closes with a frame_end result carrying status and length.
//  - csr_*: register writes (0 sync byte, 1 max length, 2 min length) are
//    always ready and take effect on the next byte; other indexes are ignored.
//  - Throughput: one byte per cycle while req_full is low, set by the parser and
//    its byte-wide CRC update. A result written at a transfer edge reaches the
//    rsp ports through the queue write and then the output register.
//  - Reset: parser back to hunting, registers to 0x5A / 1538 / 5, queue and
//    output register empty.
//  - Receiver stall: results collect in the queue (FIFO_DEPTH entries) and the
//    output register; req_full rises once the queue is full, and bytes that
//    yield no result are held back too until space frees.
module sync_length_crc16_deframer_top #(
   parameter int unsigned FIFO_DEPTH = lcdf_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_payload_len,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import lcdf_pkg::*;

   logic          in_take;
   logic          res_valid;
   result_type    res;
   result_type    q_data;
   fifo_stat_type q_stat;
   logic          q_rd;
   logic          out_valid;
   result_type    out_data;

   // Hold input while the queue has no room for a possible result
   assign req_full  = q_stat.full;
   assign in_take   = req_push && !q_stat.full;
   assign csr_ready = 1'b1;

   lcdf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_take),
      .in_byte   (req_rx_byte),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .res_valid (res_valid),
      .res       (res)
   );

   lcdf_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res),
      .rd_en   (q_rd),
      .rd_data (q_data),
      .stat    (q_stat)
   );

   lcdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_data),
      .q_rd      (q_rd),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_frame_end    = out_data.frame_end;
   assign rsp_status       = out_data.status;
   assign rsp_payload_len  = out_data.payload_len;

`ifndef SYNTH
   // The parser never produces a result into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && q_stat.full))
      else $error("result produced while queue full");

   // Result port comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result port not empty after reset");

   // Payload results carry good status, frame-end results a zero byte
   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_frame_end ? (rsp_payload_byte == 8'h00) : (rsp_status == ST_GOOD)))
      else $error("malformed result item");

   // An item taken from the queue shows on the port at the next edge
   a_load: assert property (@(posedge clock) disable iff (reset)
      q_rd |=> !rsp_empty)
      else $error("loaded result not presented");
`endif

endmodule

FILE: sim/sync_length_crc16_deframer_top_tb.sv
// Self-checking testbench for the sync/length/CRC-16 deframer top level.
`timescale 1ns / 1ps

module sync_length_crc16_deframer_top_tb;
   import lcdf_pkg::*;

   // Index outside the register map; the block must ignore writes to it.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Length of the receiver hold-off that fills the result queue.
   localparam int HOLD_CYCLES = 80;

   // Parser phases of the frame predictor.
   typedef enum logic [2:0] {
      HUNT_SYNC1,
      HUNT_SYNC2,
      LEN_LO,
      LEN_HI,
      PAYLOAD,
      CRC_LO,
      CRC_HI
   } parse_phase_type;

   // Frame predictor and store of expected results.
   class deframer_scoreboard;
      logic [7:0]      sync_val;
      logic [15:0]     len_max;
      logic [15:0]     len_min;
      parse_phase_type phase;
      logic [15:0]     frame_len;
      logic [15:0]     payload_seen;
      logic [15:0]     crc_acc;
      logic [7:0]      crc_lo;
      result_type      expected_q[$];
      int              errors;

      function new();
         sync_val     = SYNC_BYTE_RESET;
         len_max      = MAX_LENGTH_RESET;
         len_min      = MIN_LENGTH_RESET;
         phase        = HUNT_SYNC1;
         frame_len    = '0;
         payload_seen = '0;
         crc_acc      = CRC_INIT;
         crc_lo       = '0;
         errors       = 0;
      endfunction

      static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {8'h00, b};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_SYNC_BYTE:  sync_val = data[7:0];
            CSR_MAX_LENGTH: len_max  = data;
            CSR_MIN_LENGTH: len_min  = data;
            default: ;
         endcase
      endfunction

      function void queue_result(logic [7:0] pb, logic fe, logic [1:0] st, logic [15:0] len);
         result_type r;
         r.payload_byte = pb;
         r.frame_end    = fe;
         r.status       = st;
         r.payload_len  = len;
         expected_q.push_back(r);
      endfunction

      // Advance the predictor by one accepted byte.
      function void note_byte(logic [7:0] b);
         logic [15:0] next_len;
         logic [1:0]  st;
         case (phase)
            HUNT_SYNC2: begin
               if (b == sync_val) begin
                  crc_acc = crc_step(crc_acc, b);
                  phase   = LEN_LO;
               end else begin
                  phase = HUNT_SYNC1;
               end
            end
            LEN_LO: begin
               crc_acc   = crc_step(crc_acc, b);
               frame_len = {8'h00, b};
               phase     = LEN_HI;
            end
            LEN_HI: begin
               crc_acc      = crc_step(crc_acc, b);
               next_len     = {b, frame_len[7:0]};
               frame_len    = next_len;
               payload_seen = '0;
               if (next_len > len_max) begin
                  phase = HUNT_SYNC1;
                  queue_result(8'h00, 1'b1, ST_LONG, next_len);
               end else if (next_len < len_min) begin
                  phase = HUNT_SYNC1;
                  queue_result(8'h00, 1'b1, ST_SHORT, next_len);
               end else begin
                  phase = (next_len == 16'd0) ? CRC_LO : PAYLOAD;
               end
            end
            PAYLOAD: begin
               crc_acc      = crc_step(crc_acc, b);
               payload_seen = payload_seen + 16'd1;
               if (payload_seen >= frame_len) phase = CRC_LO;
               queue_result(b, 1'b0, ST_GOOD, frame_len);
            end
            CRC_LO: begin
               crc_lo = b;
               phase  = CRC_HI;
            end
            CRC_HI: begin
               st    = ({b, crc_lo} == crc_acc) ? ST_GOOD : ST_CRC;
               phase = HUNT_SYNC1;
               queue_result(8'h00, 1'b1, st, frame_len);
            end
            default: begin
               phase = HUNT_SYNC1;
               if (b == sync_val) begin
                  crc_acc = crc_step(CRC_INIT, b);
                  phase   = HUNT_SYNC2;
               end
            end
         endcase
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected result: payload_byte %0h frame_end %0b status %0d len %0d",
                   got.payload_byte, got.frame_end, got.status, got.payload_len);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.payload_byte !== exp.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", exp.payload_byte, got.payload_byte);
            errors++;
         end
         if (got.frame_end !== exp.frame_end) begin
            $error("frame_end: expected %0b, got %0b", exp.frame_end, got.frame_end);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.payload_len !== exp.payload_len) begin
            $error("payload_len: expected %0d, got %0d", exp.payload_len, got.payload_len);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_rx_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_end;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_payload_len;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   deframer_scoreboard sb;

   // Idle rates in percent per cycle, changed by the stimulus sequence.
   int unsigned send_idle;
   int unsigned recv_idle;

   // Hold-off request from the stimulus; the receiver counts it out itself.
   bit hold_req;
   int hold_left;

   // Bytes waiting to be offered, and the CRC of the frame being built.
   logic [7:0]  stream_q[$];
   logic [15:0] frame_crc;

   sync_length_crc16_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_status       (rsp_status),
      .rsp_payload_len  (rsp_payload_len),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Receiver: check each transfer on the result side, then pick the next pop.
   // All reads happen before the block's own updates land at this edge.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.payload_byte = rsp_payload_byte;
         got.frame_end    = rsp_frame_end;
         got.status       = rsp_status;
         got.payload_len  = rsp_payload_len;
         sb.check_result(got);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else if (hold_req) begin
         // Start the long stall; the sender keeps offering so req_full must rise.
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Append one byte to the stream and fold it into the frame CRC.
   function void put(logic [7:0] b);
      stream_q.push_back(b);
      frame_crc = deframer_scoreboard::crc_step(frame_crc, b);
   endfunction

   function logic [7:0] non_sync_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == sb.sync_val) b = ~b;
      return b;
   endfunction

   function void push_header(int len);
      logic [15:0] l;
      l         = 16'(len);
      frame_crc = CRC_INIT;
      put(sb.sync_val);
      put(sb.sync_val);
      put(l[7:0]);
      put(l[15:8]);
   endfunction

   // Whole frame; a patterned payload hits the byte extremes and the sync value.
   function void push_frame(int len, bit bad_crc, bit patterned);
      logic [7:0]  b;
      logic [15:0] crc;
      push_header(len);
      for (int i = 0; i < len; i++) begin
         if (patterned) begin
            case (i % 5)
               0:       b = 8'h00;
               1:       b = 8'hFF;
               2:       b = sb.sync_val;
               3:       b = 8'h80;
               default: b = 8'h01;
            endcase
         end else begin
            b = 8'($urandom);
         end
         put(b);
      end
      crc = frame_crc;
      if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
      stream_q.push_back(crc[7:0]);
      stream_q.push_back(crc[15:8]);
   endfunction

   // One random sequence, mostly well-formed frames under the current settings.
   function void push_random_sequence();
      int  sel;
      int  lo;
      int  hi;
      int  len;
      bit  can_long;
      bit  can_short;
      sel       = int'($urandom_range(99));
      lo        = int'(sb.len_min);
      hi        = int'(sb.len_max);
      can_long  = (sb.len_max != 16'hFFFF);
      can_short = (sb.len_min != 16'd0);
      if (hi - lo > 24) hi = lo + 24;
      if ((sel < 70 && lo <= hi) || (sel < 82 && !can_long && !can_short)) begin
         push_frame(lo + int'($urandom_range(hi - lo)), sel >= 58, 1'b0);
      end else if (sel < 82) begin
         if (can_long && (!can_short || $urandom_range(1) == 1)) begin
            len = int'(sb.len_max) + 1 + int'($urandom_range(3));
            if (len > 65535) len = 65535;
         end else begin
            len = int'($urandom_range(int'(sb.len_min) - 1));
         end
         push_header(len);
      end else if (sel < 92) begin
         // Broken sync: the second byte is not the sync value.
         stream_q.push_back(sb.sync_val);
         stream_q.push_back(non_sync_byte());
      end else begin
         repeat ($urandom_range(4, 1)) stream_q.push_back(non_sync_byte());
      end
   endfunction

   // Offer one byte after a random gap and hold it until the transfer.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle && gap < 40) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic send_stream();
      while (stream_q.size() != 0) send_byte(stream_q.pop_front());
   endtask

   task automatic send_random(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         push_random_sequence();
         sent += stream_q.size();
         send_stream();
      end
   endtask

   // Drop push, wait for every expected result, then let the pipeline settle.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write; valid drops again before the task returns, keeping back-to-back writes apart.
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] sync_v, input logic [15:0] max_v,
                                 input logic [15:0] min_v);
      csr_write(CSR_SYNC_BYTE, {8'h00, sync_v});
      csr_write(CSR_MAX_LENGTH, max_v);
      csr_write(CSR_MIN_LENGTH, min_v);
   endtask

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(64'd20_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_push    = 1'b0;
      req_rx_byte = 8'h00;
      rsp_pop     = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_SYNC_BYTE;
      csr_wdata   = 16'h0000;
      send_idle   = 35;
      recv_idle   = 71;
      hold_req    = 1'b0;
      hold_left   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: broken sync, too short, too long, then a good frame.
      stream_q.push_back(sb.sync_val);
      stream_q.push_back(8'h00);
      push_header(4);
      push_header(1539);
      push_frame(5, 1'b0, 1'b1);
      send_stream();

      // Stall the receiver while the sender keeps going, so the queue fills.
      hold_req = 1'b1;
      send_random(320);
      wait_drained();

      // Extremes: sync 0x00 and only zero-length frames accepted.
      apply_settings(8'h00, 16'h0000, 16'h0000);
      csr_write(CSR_UNUSED, 16'hFFFF);
      push_frame(0, 1'b0, 1'b0);
      push_frame(0, 1'b1, 1'b0);
      send_stream();
      send_random(300);
      wait_drained();

      // Minimum above maximum: the too-long check must win.
      send_idle = 71;
      recv_idle = 35;
      apply_settings(8'hFF, 16'h0000, 16'hFFFF);
      push_header(0);
      push_header(1);
      send_stream();
      send_random(250);
      wait_drained();

      // Widest maximum, so no length can be too long.
      apply_settings(8'($urandom), 16'hFFFF, 16'd1);
      send_random(350);
      wait_drained();

      // No idling on either side.
      send_idle = 0;
      recv_idle = 0;
      apply_settings(8'($urandom), 16'($urandom_range(40, 20)), 16'($urandom_range(4)));
      send_random(400);
      wait_drained();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/lcdf_pkg.sv
src/lcdf_front.sv
src/lcdf_fifo.sv
src/lcdf_back.sv
src/sync_length_crc16_deframer_top.sv
sim/sync_length_crc16_deframer_top_tb.sv
